### rtl/core/mrhp_pkg.sv
// ----------------------------------------------------------------------------
// mrhp_pkg
// Types, field codes and per-phase tables for the mesh routing header parser.
// ----------------------------------------------------------------------------
`default_nettype none

package mrhp_pkg;

    typedef enum logic [4:0] {
        PH_IDLE    = 5'd0,
        PH_SRC     = 5'd1,
        PH_SEQ     = 5'd2,
        PH_BINT    = 5'd3,
        PH_NCNT    = 5'd4,
        PH_MCNT    = 5'd5,
        PH_NADDR   = 5'd6,
        PH_MADDR   = 5'd7,
        PH_LASTHOP = 5'd8,
        PH_FTTL    = 5'd9,
        PH_DEST    = 5'd10,
        PH_NEXTHOP = 5'd11,
        PH_UTTL    = 5'd12,
        PH_SUBTYPE = 5'd13,
        PH_VALID   = 5'd14,
        PH_LCNT    = 5'd15,
        PH_LADDR   = 5'd16,
        PH_COST    = 5'd17,
        PH_NLEN    = 5'd18,
        PH_NAME    = 5'd19,
        PH_IV      = 5'd20,
        PH_NONCE   = 5'd21,
        PH_DATA    = 5'd22,
        PH_DONE    = 5'd23
    } phase_t;

    typedef logic [4:0] field_code_t;

    localparam field_code_t CODE_TYPE_FLAGS = 5'd0;
    localparam field_code_t CODE_SRC        = 5'd1;
    localparam field_code_t CODE_SEQ        = 5'd2;
    localparam field_code_t CODE_INTERVAL   = 5'd3;
    localparam field_code_t CODE_NCOUNT     = 5'd4;
    localparam field_code_t CODE_MCOUNT     = 5'd5;
    localparam field_code_t CODE_NADDR      = 5'd6;
    localparam field_code_t CODE_MADDR      = 5'd7;
    localparam field_code_t CODE_LASTHOP    = 5'd8;
    localparam field_code_t CODE_TTL        = 5'd9;
    localparam field_code_t CODE_DEST       = 5'd10;
    localparam field_code_t CODE_NEXTHOP    = 5'd11;
    localparam field_code_t CODE_SUBTYPE    = 5'd12;
    localparam field_code_t CODE_VALIDITY   = 5'd13;
    localparam field_code_t CODE_LCOUNT     = 5'd14;
    localparam field_code_t CODE_LADDR      = 5'd15;
    localparam field_code_t CODE_COST       = 5'd16;
    localparam field_code_t CODE_NAME_LEN   = 5'd17;
    localparam field_code_t CODE_NAME_BYTE  = 5'd18;
    localparam field_code_t CODE_IV         = 5'd19;
    localparam field_code_t CODE_NONCE      = 5'd20;
    localparam field_code_t CODE_EMBEDDED   = 5'd21;

    localparam logic [1:0] TYPE_BEACON  = 2'd0;
    localparam logic [1:0] TYPE_FLOOD   = 2'd1;
    localparam logic [1:0] TYPE_UNICAST = 2'd2;
    localparam logic [1:0] TYPE_FLOW    = 2'd3;

    localparam logic [7:0] SUB_TOPO   = 8'h00;
    localparam logic [7:0] SUB_CRYPTO = 8'h63;
    localparam logic [7:0] SUB_DATA   = 8'h62;

    // bytes in the field gathered during a phase
    function automatic logic [3:0] phase_len(input phase_t ph);
        logic [3:0] len;
        unique case (ph)
            PH_SRC, PH_MADDR, PH_NADDR, PH_LASTHOP,
            PH_DEST, PH_NEXTHOP, PH_LADDR:          len = 4'd6;
            PH_SEQ, PH_BINT, PH_COST:               len = 4'd2;
            PH_VALID:                               len = 4'd4;
            PH_IV, PH_NONCE:                        len = 4'd8;
            PH_NCNT, PH_MCNT, PH_FTTL, PH_UTTL, PH_SUBTYPE,
            PH_LCNT, PH_NLEN, PH_NAME, PH_DATA:     len = 4'd1;
            default:                                len = 4'd0;
        endcase
        return len;
    endfunction

    function automatic field_code_t phase_code(input phase_t ph);
        field_code_t code;
        unique case (ph)
            PH_SRC:     code = CODE_SRC;
            PH_SEQ:     code = CODE_SEQ;
            PH_BINT:    code = CODE_INTERVAL;
            PH_NCNT:    code = CODE_NCOUNT;
            PH_MCNT:    code = CODE_MCOUNT;
            PH_NADDR:   code = CODE_NADDR;
            PH_MADDR:   code = CODE_MADDR;
            PH_LASTHOP: code = CODE_LASTHOP;
            PH_FTTL:    code = CODE_TTL;
            PH_DEST:    code = CODE_DEST;
            PH_NEXTHOP: code = CODE_NEXTHOP;
            PH_UTTL:    code = CODE_TTL;
            PH_SUBTYPE: code = CODE_SUBTYPE;
            PH_VALID:   code = CODE_VALIDITY;
            PH_LCNT:    code = CODE_LCOUNT;
            PH_LADDR:   code = CODE_LADDR;
            PH_COST:    code = CODE_COST;
            PH_NLEN:    code = CODE_NAME_LEN;
            PH_NAME:    code = CODE_NAME_BYTE;
            PH_IV:      code = CODE_IV;
            PH_NONCE:   code = CODE_NONCE;
            PH_DATA:    code = CODE_EMBEDDED;
            default:    code = CODE_TYPE_FLAGS;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

### rtl/core/mesh_routing_header_parser_unit.sv
// ----------------------------------------------------------------------------
// mesh_routing_header_parser_unit
// Byte-serial mesh routing header parser emitting one record per field.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid/in_ready): one frame byte per transfer, with
//   start_of_packet high on the first byte of each frame. A start byte always
//   restarts the parser, even in mid-frame.
//   Output channel (out_valid/out_ready): one record per completed field,
//   carrying field_code, the big-endian field_value, element_index inside a
//   counted list or name, the frame_type of the current frame and frame_done
//   on the last decodable field.
//   Timing: a record appears in the cycle after the transfer of the last byte
//   of its field. Bytes in the middle of a field, before any start, or after
//   the end of the decodable part produce no record.
//   Throughput: one byte per cycle while no record is stalled on out_ready,
//   set by the single byte-wide phase update that feeds the output register.
//   Stall: in_ready follows the output register; while a record waits on
//   out_ready the next byte is held off, and taking a record frees the slot
//   in the same cycle.
//   Reset: the parser goes idle and ignores bytes until a start byte; the
//   output register is emptied.
// ----------------------------------------------------------------------------
`default_nettype none

module mesh_routing_header_parser_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        start_of_packet,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [4:0]       field_code,
    output logic [63:0]      field_value,
    output logic [7:0]       element_index,
    output logic [1:0]       frame_type,
    output logic             frame_done
);

    mrhp_pkg::phase_t phase_reg, phase_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [63:0] acc_reg, acc_next;
    logic [7:0]  rem_reg, rem_next;
    logic [7:0]  second_reg, second_next;
    logic [7:0]  pos_reg, pos_next;
    logic [1:0]  ftype_reg, ftype_next;

    logic        out_valid_reg, out_valid_next;
    logic [4:0]  code_reg;
    logic [63:0] value_reg;
    logic [7:0]  index_reg;
    logic [1:0]  type_reg;
    logic        done_reg;

    logic        in_fire;
    logic        emit;
    logic [4:0]  emit_code;
    logic [63:0] emit_value;
    logic [7:0]  emit_index;
    logic [1:0]  emit_type;
    logic        emit_done;
    logic [63:0] acc_shift;
    logic [3:0]  cnt_plus;
    logic [7:0]  rem_dec;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    assign acc_shift = {acc_reg[55:0], data_byte};
    assign cnt_plus  = {1'b0, cnt_reg} + 4'd1;
    assign rem_dec   = rem_reg - 8'd1;

    always_comb
    begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        rem_next    = rem_reg;
        second_next = second_reg;
        pos_next    = pos_reg;
        ftype_next  = ftype_reg;
        emit        = 1'b0;
        emit_code   = mrhp_pkg::CODE_TYPE_FLAGS;
        emit_value  = acc_shift;
        emit_index  = 8'd0;
        emit_type   = ftype_reg;
        emit_done   = 1'b0;

        if (in_fire)
        begin
            if (start_of_packet)
            begin
                ftype_next  = data_byte[1:0];
                phase_next  = mrhp_pkg::PH_SRC;
                cnt_next    = 3'd0;
                acc_next    = 64'd0;
                rem_next    = 8'd0;
                second_next = 8'd0;
                pos_next    = 8'd0;
                emit        = 1'b1;
                emit_code   = mrhp_pkg::CODE_TYPE_FLAGS;
                emit_value  = {56'd0, data_byte};
                emit_type   = data_byte[1:0];
            end
            else if (phase_reg == mrhp_pkg::PH_IDLE || phase_reg == mrhp_pkg::PH_DONE)
            begin
                // outside a frame: byte dropped
            end
            else if (phase_reg == mrhp_pkg::PH_DATA)
            begin
                emit       = 1'b1;
                emit_code  = mrhp_pkg::CODE_EMBEDDED;
                emit_value = {56'd0, data_byte};
            end
            else if (cnt_plus < mrhp_pkg::phase_len(phase_reg))
            begin
                acc_next = acc_shift;
                cnt_next = cnt_reg + 3'd1;
            end
            else
            begin
                acc_next  = 64'd0;
                cnt_next  = 3'd0;
                emit      = 1'b1;
                emit_code = mrhp_pkg::phase_code(phase_reg);
                unique case (phase_reg)
                    mrhp_pkg::PH_SRC:     phase_next = mrhp_pkg::PH_SEQ;
                    mrhp_pkg::PH_SEQ:
                    begin
                        if (ftype_reg == mrhp_pkg::TYPE_BEACON)
                            phase_next = mrhp_pkg::PH_BINT;
                        else if (ftype_reg == mrhp_pkg::TYPE_FLOOD)
                            phase_next = mrhp_pkg::PH_LASTHOP;
                        else if (ftype_reg == mrhp_pkg::TYPE_UNICAST)
                            phase_next = mrhp_pkg::PH_DEST;
                        else
                        begin
                            phase_next = mrhp_pkg::PH_DONE;
                            emit_done  = 1'b1;
                        end
                    end
                    mrhp_pkg::PH_BINT:    phase_next = mrhp_pkg::PH_NCNT;
                    mrhp_pkg::PH_NCNT:
                    begin
                        rem_next   = acc_shift[7:0];
                        phase_next = mrhp_pkg::PH_MCNT;
                    end
                    mrhp_pkg::PH_MCNT:
                    begin
                        second_next = acc_shift[7:0];
                        pos_next    = 8'd0;
                        if (rem_reg != 8'd0)
                            phase_next = mrhp_pkg::PH_NADDR;
                        else if (acc_shift[7:0] != 8'd0)
                        begin
                            rem_next   = acc_shift[7:0];
                            phase_next = mrhp_pkg::PH_MADDR;
                        end
                        else
                        begin
                            phase_next = mrhp_pkg::PH_DONE;
                            emit_done  = 1'b1;
                        end
                    end
                    mrhp_pkg::PH_NADDR, mrhp_pkg::PH_MADDR:
                    begin
                        emit_index = pos_reg;
                        pos_next   = pos_reg + 8'd1;
                        rem_next   = rem_dec;
                        if (rem_dec == 8'd0)
                        begin
                            // first list exhausted: move on to the relay list
                            if (phase_reg == mrhp_pkg::PH_NADDR && second_reg != 8'd0)
                            begin
                                rem_next   = second_reg;
                                pos_next   = 8'd0;
                                phase_next = mrhp_pkg::PH_MADDR;
                            end
                            else
                            begin
                                phase_next = mrhp_pkg::PH_DONE;
                                emit_done  = 1'b1;
                            end
                        end
                    end
                    mrhp_pkg::PH_LASTHOP: phase_next = mrhp_pkg::PH_FTTL;
                    mrhp_pkg::PH_FTTL:    phase_next = mrhp_pkg::PH_SUBTYPE;
                    mrhp_pkg::PH_DEST:    phase_next = mrhp_pkg::PH_NEXTHOP;
                    mrhp_pkg::PH_NEXTHOP: phase_next = mrhp_pkg::PH_UTTL;
                    mrhp_pkg::PH_UTTL:    phase_next = mrhp_pkg::PH_SUBTYPE;
                    mrhp_pkg::PH_SUBTYPE:
                    begin
                        if (acc_shift[7:0] == mrhp_pkg::SUB_TOPO)
                            phase_next = mrhp_pkg::PH_VALID;
                        else if (acc_shift[7:0] == mrhp_pkg::SUB_CRYPTO)
                            phase_next = mrhp_pkg::PH_IV;
                        else if (acc_shift[7:0] == mrhp_pkg::SUB_DATA)
                            phase_next = mrhp_pkg::PH_DATA;
                        else
                        begin
                            phase_next = mrhp_pkg::PH_DONE;
                            emit_done  = 1'b1;
                        end
                    end
                    mrhp_pkg::PH_VALID:   phase_next = mrhp_pkg::PH_LCNT;
                    mrhp_pkg::PH_LCNT:
                    begin
                        rem_next   = acc_shift[7:0];
                        pos_next   = 8'd0;
                        phase_next = (acc_shift[7:0] != 8'd0) ? mrhp_pkg::PH_LADDR
                                                              : mrhp_pkg::PH_NLEN;
                    end
                    mrhp_pkg::PH_LADDR:
                    begin
                        emit_index = pos_reg;
                        phase_next = mrhp_pkg::PH_COST;
                    end
                    mrhp_pkg::PH_COST:
                    begin
                        emit_index = pos_reg;
                        pos_next   = pos_reg + 8'd1;
                        rem_next   = rem_dec;
                        phase_next = (rem_dec == 8'd0) ? mrhp_pkg::PH_NLEN
                                                       : mrhp_pkg::PH_LADDR;
                    end
                    mrhp_pkg::PH_NLEN:
                    begin
                        rem_next = acc_shift[7:0];
                        pos_next = 8'd0;
                        if (acc_shift[7:0] != 8'd0)
                            phase_next = mrhp_pkg::PH_NAME;
                        else
                        begin
                            phase_next = mrhp_pkg::PH_DONE;
                            emit_done  = 1'b1;
                        end
                    end
                    mrhp_pkg::PH_NAME:
                    begin
                        emit_index = pos_reg;
                        pos_next   = pos_reg + 8'd1;
                        rem_next   = rem_dec;
                        if (rem_dec == 8'd0)
                        begin
                            phase_next = mrhp_pkg::PH_DONE;
                            emit_done  = 1'b1;
                        end
                    end
                    mrhp_pkg::PH_IV:      phase_next = mrhp_pkg::PH_NONCE;
                    mrhp_pkg::PH_NONCE:
                    begin
                        phase_next = mrhp_pkg::PH_DONE;
                        emit_done  = 1'b1;
                    end
                    default:              phase_next = mrhp_pkg::PH_DONE;
                endcase
            end
        end
    end

    always_comb
    begin
        if (emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= mrhp_pkg::PH_IDLE;
            cnt_reg       <= 3'd0;
            acc_reg       <= 64'd0;
            rem_reg       <= 8'd0;
            second_reg    <= 8'd0;
            pos_reg       <= 8'd0;
            ftype_reg     <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            acc_reg       <= acc_next;
            rem_reg       <= rem_next;
            second_reg    <= second_next;
            pos_reg       <= pos_next;
            ftype_reg     <= ftype_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, loaded only when a record is produced
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            code_reg  <= emit_code;
            value_reg <= emit_value;
            index_reg <= emit_index;
            type_reg  <= emit_type;
            done_reg  <= emit_done;
        end
    end

    assign out_valid     = out_valid_reg;
    assign field_code    = code_reg;
    assign field_value   = value_reg;
    assign element_index = index_reg;
    assign frame_type    = type_reg;
    assign frame_done    = done_reg;

endmodule

`default_nettype wire

### rtl/core/mrhp_checker.sv
// ----------------------------------------------------------------------------
// mrhp_checker
// Port-level checks for the mesh routing header parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mrhp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic [7:0]  data_byte,
    input wire logic        start_of_packet,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [4:0]  field_code,
    input wire logic [63:0] field_value,
    input wire logic [7:0]  element_index,
    input wire logic [1:0]  frame_type,
    input wire logic        frame_done
);

    // a stalled record stays up
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("record dropped while stalled");

    // a stalled record keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(field_value) && $stable(field_code)
            && $stable(element_index) && $stable(frame_done))
        else $error("record payload changed while stalled");

    // a start byte always yields the type and flags record
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && start_of_packet |=>
            out_valid && field_code == mrhp_pkg::CODE_TYPE_FLAGS
            && field_value == {56'd0, $past(data_byte)}
            && frame_type == $past(data_byte[1:0]) && !frame_done)
        else $error("start byte did not produce its record");

    // embedded bytes are single bytes outside any list and never end a frame
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && field_code == mrhp_pkg::CODE_EMBEDDED |->
            !frame_done && element_index == 8'd0 && field_value[63:8] == 56'd0)
        else $error("malformed embedded byte record");

endmodule

bind mesh_routing_header_parser_unit mrhp_checker u_mrhp_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .data_byte       (data_byte),
    .start_of_packet (start_of_packet),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .field_code      (field_code),
    .field_value     (field_value),
    .element_index   (element_index),
    .frame_type      (frame_type),
    .frame_done      (frame_done)
);

`default_nettype wire
